// ===== rtl/fsg_pkg.sv =====
// Shared types, sizes and address helper for the falling-sand grid block.
// No dependencies; used by every module of the block.
package fsg_pkg;

  localparam int ROWS       = 128;
  localparam int COLS       = 256;
  localparam int RW         = $clog2(ROWS);
  localparam int CW         = $clog2(COLS);
  localparam int BANK_ROWS  = (ROWS + 1) / 2;
  localparam int BANK_DEPTH = BANK_ROWS * COLS;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);
  localparam int COLOR_W    = 24;

  typedef logic [COLOR_W-1:0] color_t;

  localparam logic [1:0] MODE_STEP  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam color_t CLEAR_COLOR = '0;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] row;
    logic [7:0] col;
    color_t     color;
  } in_t;

  typedef struct packed {
    color_t read_color;
    logic   step_done;
  } out_t;

  typedef struct packed {
    logic load;
    logic visit;
    logic left_ok;
  } vis_ctl_t;

  typedef struct packed {
    logic   hi_wr;
    logic   moved;
    color_t hi_data;
  } vis_res_t;

  // Rows alternate between two banks; each bank holds every second row.
  function automatic logic [BANK_AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                   input logic [CW-1:0] c);
    logic [BANK_AW-1:0] half;
    half = BANK_AW'(r >> 1);
    return BANK_AW'(half * BANK_AW'(COLS)) + BANK_AW'(c);
  endfunction

endpackage

// ===== rtl/fsg_bank.sv =====
// One bank of the cell store: one write port, one registered read port.
// Depends on fsg_pkg for depth and widths.
module fsg_bank (
  input  logic                        clk,
  input  logic                        we,
  input  logic [fsg_pkg::BANK_AW-1:0] waddr,
  input  fsg_pkg::color_t             wdata,
  input  logic                        re,
  input  logic [fsg_pkg::BANK_AW-1:0] raddr,
  output fsg_pkg::color_t             rdata
);

  fsg_pkg::color_t mem [fsg_pkg::BANK_DEPTH];
  fsg_pkg::color_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fsg_visit.sv =====
// Sweep window: holds the cells around the current column and decides moves.
// Depends on fsg_pkg for the colour type and control structs.
module fsg_visit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsg_pkg::vis_ctl_t    ctl,
  input  fsg_pkg::color_t      bg,
  input  fsg_pkg::color_t      rd_dn,
  input  fsg_pkg::color_t      rd_up,
  output fsg_pkg::vis_res_t    res
);

  fsg_pkg::color_t hi_r;
  fsg_pkg::color_t mid_r;
  fsg_pkg::color_t up_r;
  logic            hi_ok_r;

  logic            grain;
  logic            mid_e;
  logic            left_e;
  logic            hi_e;
  logic            mv_mid;
  logic            mv_left;
  logic            mv_hi;
  fsg_pkg::color_t mid_new;
  fsg_pkg::color_t left_new;
  fsg_pkg::color_t hi_new;

  always_comb begin
    grain    = ctl.visit && (up_r != bg);
    mid_e    = (mid_r == bg);
    left_e   = ctl.left_ok && (rd_dn == bg);
    hi_e     = hi_ok_r && (hi_r == bg);
    mv_mid   = grain && mid_e;
    mv_left  = grain && !mid_e && left_e;
    mv_hi    = grain && !mid_e && !left_e && hi_e;
    mid_new  = mv_mid  ? up_r : mid_r;
    left_new = mv_left ? up_r : rd_dn;
    hi_new   = mv_hi   ? up_r : hi_r;
    res.hi_wr   = ctl.visit && hi_ok_r;
    res.moved   = mv_mid || mv_left || mv_hi;
    res.hi_data = hi_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_ok_r <= 1'b0;
    end else if (ctl.load) begin
      hi_ok_r <= 1'b0;
    end else if (ctl.visit) begin
      hi_ok_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mid_r <= rd_dn;
      up_r  <= rd_up;
    end else if (ctl.visit) begin
      hi_r  <= mid_new;
      mid_r <= left_new;
      up_r  <= rd_up;
    end
  end

endmodule

// ===== rtl/falling_sand_grid_step_top.sv =====
// Top level of the falling-sand grid: request sequencer, two row banks, sweep window.
// Depends on fsg_pkg, fsg_bank and fsg_visit.
//
//   port group   direction   handshake            payload
//   in_          request in  in_valid/in_ready    in_data   (fsg_pkg::in_t)
//   out_         result out  out_valid/out_ready  out_data  (fsg_pkg::out_t)
//   cfg_         write in    cfg_valid/cfg_ready  cfg_data  (background colour)
//
// A read request waits on the bank read latency; a write request does not.
// A sweep request handles one column per cycle through both banks.
// After reset both banks are cleared, all BANK_DEPTH (16384) addresses; in_ready stays low.
// One request is in flight at a time; a stalled result holds in the output register.
module falling_sand_grid_step_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fsg_pkg::in_t                in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output fsg_pkg::out_t               out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fsg_pkg::COLOR_W-1:0] cfg_data
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_READ  = 8'b0000_0100,
    S_ROW   = 8'b0000_1000,
    S_V0    = 8'b0001_0000,
    S_E0    = 8'b0010_0000,
    S_W0    = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [fsg_pkg::BANK_AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic [fsg_pkg::RW-1:0]        row_r, row_nxt;
  logic [fsg_pkg::CW-1:0]        rc_r, rc_nxt;
  logic                          rd_bank_r, rd_bank_nxt;
  logic                          rd_ok_r, rd_ok_nxt;
  fsg_pkg::out_t                 res_r, res_nxt;
  fsg_pkg::out_t                 out_r;
  logic                          out_valid_r;
  fsg_pkg::color_t               bg_r;

  logic                          bk_we    [2];
  logic [fsg_pkg::BANK_AW-1:0]   bk_waddr [2];
  fsg_pkg::color_t               bk_wdata [2];
  logic                          bk_re    [2];
  logic [fsg_pkg::BANK_AW-1:0]   bk_raddr [2];
  fsg_pkg::color_t               bk_rdata [2];

  fsg_pkg::vis_ctl_t             vctl;
  fsg_pkg::vis_res_t             vres;
  logic [fsg_pkg::CW-1:0]        c_vis;
  logic [fsg_pkg::CW-1:0]        c_hi;
  logic [fsg_pkg::RW-1:0]        row_up;
  logic                          b_dn;
  logic                          b_up;
  logic [fsg_pkg::RW-1:0]        in_row;
  logic [fsg_pkg::CW-1:0]        in_col;
  logic                          on_grid;
  logic                          out_free;

  for (genvar b = 0; b < 2; b++) begin : g_bank
    fsg_bank u_bank (
      .clk   (clk),
      .we    (bk_we[b]),
      .waddr (bk_waddr[b]),
      .wdata (bk_wdata[b]),
      .re    (bk_re[b]),
      .raddr (bk_raddr[b]),
      .rdata (bk_rdata[b])
    );
  end

  assign b_dn   = row_r[0];
  assign b_up   = ~row_r[0];
  assign row_up = fsg_pkg::RW'(row_r - 1'b1);

  fsg_visit u_visit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (vctl),
    .bg    (bg_r),
    .rd_dn (bk_rdata[b_dn]),
    .rd_up (bk_rdata[b_up]),
    .res   (vres)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;
  assign in_row    = fsg_pkg::RW'(in_data.row);
  assign in_col    = fsg_pkg::CW'(in_data.col);
  assign on_grid   = (32'(in_data.row) < fsg_pkg::ROWS) && (32'(in_data.col) < fsg_pkg::COLS);
  assign c_hi      = fsg_pkg::CW'(c_vis + 1'b1);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    row_nxt      = row_r;
    rc_nxt       = rc_r;
    rd_bank_nxt  = rd_bank_r;
    rd_ok_nxt    = rd_ok_r;
    res_nxt      = res_r;
    vctl         = '0;
    c_vis        = '0;
    for (int b = 0; b < 2; b++) begin
      bk_we[b]    = 1'b0;
      bk_waddr[b] = '0;
      bk_wdata[b] = '0;
      bk_re[b]    = 1'b0;
      bk_raddr[b] = '0;
    end

    case (state_r)
      S_CLEAR: begin
        for (int b = 0; b < 2; b++) begin
          bk_we[b]    = 1'b1;
          bk_waddr[b] = clr_addr_r;
          bk_wdata[b] = fsg_pkg::CLEAR_COLOR;
        end
        clr_addr_nxt = fsg_pkg::BANK_AW'(clr_addr_r + 1'b1);
        if (clr_addr_r == fsg_pkg::BANK_AW'(fsg_pkg::BANK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_nxt = '0;
          case (in_data.mode)
            fsg_pkg::MODE_STEP: begin
              res_nxt.step_done = 1'b1;
              row_nxt           = fsg_pkg::RW'(fsg_pkg::ROWS - 1);
              rc_nxt            = fsg_pkg::CW'(fsg_pkg::COLS - 1);
              state_nxt         = S_ROW;
            end
            fsg_pkg::MODE_WRITE: begin
              bk_we[in_row[0]]    = on_grid;
              bk_waddr[in_row[0]] = fsg_pkg::cell_addr(in_row, in_col);
              bk_wdata[in_row[0]] = in_data.color;
              state_nxt           = S_FIN;
            end
            fsg_pkg::MODE_READ: begin
              bk_re[in_row[0]]    = on_grid;
              bk_raddr[in_row[0]] = fsg_pkg::cell_addr(in_row, in_col);
              rd_bank_nxt         = in_row[0];
              rd_ok_nxt           = on_grid;
              state_nxt           = S_READ;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_READ: begin
        res_nxt.read_color = rd_ok_r ? bk_rdata[rd_bank_r] : '0;
        res_nxt.step_done  = 1'b0;
        state_nxt          = S_FIN;
      end
      S_ROW: begin
        bk_re[b_dn]    = 1'b1;
        bk_raddr[b_dn] = fsg_pkg::cell_addr(row_r, rc_r);
        bk_re[b_up]    = 1'b1;
        bk_raddr[b_up] = fsg_pkg::cell_addr(row_up, rc_r);
        if (rc_r == fsg_pkg::CW'(fsg_pkg::COLS - 2)) begin
          vctl.load = 1'b1;
        end else if (rc_r != fsg_pkg::CW'(fsg_pkg::COLS - 1)) begin
          vctl.visit   = 1'b1;
          vctl.left_ok = 1'b1;
          c_vis        = fsg_pkg::CW'(rc_r + 2'd2);
        end
        if (rc_r == '0) begin
          state_nxt = S_V0;
        end else begin
          rc_nxt = fsg_pkg::CW'(rc_r - 1'b1);
        end
      end
      S_V0: begin
        vctl.visit   = 1'b1;
        vctl.left_ok = 1'b1;
        c_vis        = fsg_pkg::CW'(1);
        state_nxt    = S_E0;
      end
      S_E0: begin
        vctl.visit = 1'b1;
        c_vis      = '0;
        state_nxt  = S_W0;
      end
      S_W0: begin
        bk_we[b_dn]    = 1'b1;
        bk_waddr[b_dn] = fsg_pkg::cell_addr(row_r, '0);
        bk_wdata[b_dn] = vres.hi_data;
        if (row_r == fsg_pkg::RW'(1)) begin
          state_nxt = S_FIN;
        end else begin
          row_nxt   = row_up;
          rc_nxt    = fsg_pkg::CW'(fsg_pkg::COLS - 1);
          state_nxt = S_ROW;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (vctl.visit) begin
      bk_we[b_dn]    = vres.hi_wr;
      bk_waddr[b_dn] = fsg_pkg::cell_addr(row_r, c_hi);
      bk_wdata[b_dn] = vres.hi_data;
      bk_we[b_up]    = vres.moved;
      bk_waddr[b_up] = fsg_pkg::cell_addr(row_up, c_vis);
      bk_wdata[b_up] = bg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
      rd_ok_r    <= 1'b0;
      bg_r       <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      rd_ok_r    <= rd_ok_nxt;
      if (cfg_valid) begin
        bg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    rc_r      <= rc_nxt;
    rd_bank_r <= rd_bank_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/fsg_chk.sv =====
// Port-level checks for the falling-sand grid top level, attached by bind.
// Depends on fsg_pkg and falling_sand_grid_step_top.
module fsg_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input fsg_pkg::out_t               out_data
);

  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken while the store is being cleared");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken before the first completed");

  a_step_no_colour: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.step_done |-> out_data.read_color == '0)
    else $error("sweep result carries a colour");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind falling_sand_grid_step_top fsg_chk u_fsg_chk (.*);
